// ===== sv/nia_pkg.sv =====
// ---------------------------------------------------------------------------
// nia_pkg: shared types and constants of the null-aware integer ALU
// Opcodes, request and result structs, and the payload that the cell chain
// carries from one cell to the next.
// ---------------------------------------------------------------------------
package nia_pkg;

  localparam int unsigned DataW  = 64;
  localparam int unsigned NCells = 64;  // one multiply or divide step per cell
  localparam int unsigned Latency = NCells + 2;

  localparam logic [4:0] OP_ADD     = 5'd0;
  localparam logic [4:0] OP_SUB     = 5'd1;
  localparam logic [4:0] OP_MUL     = 5'd2;
  localparam logic [4:0] OP_DIV     = 5'd3;
  localparam logic [4:0] OP_MOD     = 5'd4;
  localparam logic [4:0] OP_EQ      = 5'd5;
  localparam logic [4:0] OP_NE      = 5'd6;
  localparam logic [4:0] OP_LT      = 5'd7;
  localparam logic [4:0] OP_LE      = 5'd8;
  localparam logic [4:0] OP_GT      = 5'd9;
  localparam logic [4:0] OP_GE      = 5'd10;
  localparam logic [4:0] OP_AND     = 5'd11;
  localparam logic [4:0] OP_OR      = 5'd12;
  localparam logic [4:0] OP_ABS     = 5'd13;
  localparam logic [4:0] OP_NEG     = 5'd14;
  localparam logic [4:0] OP_NOT     = 5'd15;
  localparam logic [4:0] OP_ISNULL  = 5'd16;
  localparam logic [4:0] OP_NOTNULL = 5'd17;

  localparam logic KIND_INT  = 1'b0;
  localparam logic KIND_BOOL = 1'b1;

  // which value the back end picks
  typedef enum logic [1:0] {
    SEL_DIRECT = 2'd0,
    SEL_MUL    = 2'd1,
    SEL_DIV    = 2'd2,
    SEL_MOD    = 2'd3
  } sel_e;

  typedef struct packed {
    logic [4:0]              req_type;
    logic signed [DataW-1:0] left_value;
    logic                    left_null;
    logic                    left_kind;
    logic signed [DataW-1:0] right_value;
    logic                    right_null;
    logic                    right_kind;
  } req_t;

  typedef struct packed {
    logic signed [DataW-1:0] result_value;
    logic                    result_null;
    logic                    result_kind;
    logic                    type_error;
  } rsp_t;

  // payload handed along the cell chain
  typedef struct packed {
    sel_e             sel;
    logic [DataW-1:0] val;   // finished value for direct ops
    logic             nul;
    logic             knd;
    logic             err;
    logic             qneg;  // quotient to be negated
    logic             rneg;  // remainder to be negated
    logic [DataW-1:0] acc;   // product or partial remainder
    logic [DataW-1:0] opa;   // multiplicand, or dividend turning into quotient
    logic [DataW-1:0] opb;   // multiplier, or divisor magnitude
  } cell_t;

endpackage

// ===== sv/nia_front.sv =====
// ---------------------------------------------------------------------------
// nia_front: decode and typing stage
// Checks operand kinds and nulls, finishes the simple ops and loads the
// operands of multiply, divide and remainder for the cell chain.
// ---------------------------------------------------------------------------
module nia_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           vld_i,
  input  nia_pkg::req_t  req_i,
  output logic           vld_o,
  output nia_pkg::cell_t data_o
);

  logic           vld_q;
  nia_pkg::cell_t data_d, data_q;

  logic [nia_pkg::DataW-1:0] l, r;
  logic ln, lk, rn, rk, lb, rb, slt, sgt;

  assign l   = req_i.left_value;
  assign r   = req_i.right_value;
  assign ln  = req_i.left_null;
  assign lk  = req_i.left_kind;
  assign rn  = req_i.right_null;
  assign rk  = req_i.right_kind;
  assign lb  = |l;
  assign rb  = |r;
  assign slt = $signed(l) < $signed(r);
  assign sgt = $signed(r) < $signed(l);

  // classify the request
  always_comb begin
    data_d      = '0;
    data_d.sel  = nia_pkg::SEL_DIRECT;
    data_d.qneg = l[nia_pkg::DataW-1] ^ r[nia_pkg::DataW-1];
    data_d.rneg = l[nia_pkg::DataW-1];
    case (req_i.req_type)
      nia_pkg::OP_ADD, nia_pkg::OP_SUB, nia_pkg::OP_MUL,
      nia_pkg::OP_DIV, nia_pkg::OP_MOD: begin
        if (lk || rk) begin
          data_d.err = 1'b1;
        end else if (ln || rn) begin
          data_d.nul = 1'b1;
        end else begin
          case (req_i.req_type)
            nia_pkg::OP_ADD: data_d.val = l + r;
            nia_pkg::OP_SUB: data_d.val = l - r;
            nia_pkg::OP_MUL: begin
              data_d.sel = nia_pkg::SEL_MUL;
              data_d.opa = l;
              data_d.opb = r;
            end
            default: begin
              if (!rb) begin
                data_d.nul = 1'b1;
              end else begin
                data_d.sel = (req_i.req_type == nia_pkg::OP_DIV) ?
                             nia_pkg::SEL_DIV : nia_pkg::SEL_MOD;
                // magnitudes; the most negative value maps to 2^63 unsigned
                data_d.opa = l[nia_pkg::DataW-1] ? (~l + 1'b1) : l;
                data_d.opb = r[nia_pkg::DataW-1] ? (~r + 1'b1) : r;
              end
            end
          endcase
        end
      end
      nia_pkg::OP_EQ, nia_pkg::OP_NE, nia_pkg::OP_LT, nia_pkg::OP_LE,
      nia_pkg::OP_GT, nia_pkg::OP_GE, nia_pkg::OP_AND, nia_pkg::OP_OR: begin
        if (ln || rn) begin
          data_d.nul = 1'b1;
          data_d.knd = nia_pkg::KIND_BOOL;
        end else if (req_i.req_type == nia_pkg::OP_AND ||
                     req_i.req_type == nia_pkg::OP_OR) begin
          if (!lk || !rk) begin
            data_d.err = 1'b1;
          end else begin
            data_d.knd    = nia_pkg::KIND_BOOL;
            data_d.val[0] = (req_i.req_type == nia_pkg::OP_AND) ? (lb & rb) : (lb | rb);
          end
        end else if (lk != rk) begin
          data_d.err = 1'b1;
        end else if (lk) begin
          if (req_i.req_type == nia_pkg::OP_EQ) begin
            data_d.knd    = nia_pkg::KIND_BOOL;
            data_d.val[0] = lb == rb;
          end else if (req_i.req_type == nia_pkg::OP_NE) begin
            data_d.knd    = nia_pkg::KIND_BOOL;
            data_d.val[0] = lb != rb;
          end else begin
            data_d.err = 1'b1;
          end
        end else begin
          data_d.knd = nia_pkg::KIND_BOOL;
          case (req_i.req_type)
            nia_pkg::OP_EQ: data_d.val[0] = l == r;
            nia_pkg::OP_NE: data_d.val[0] = l != r;
            nia_pkg::OP_LT: data_d.val[0] = slt;
            nia_pkg::OP_LE: data_d.val[0] = !sgt;
            nia_pkg::OP_GT: data_d.val[0] = sgt;
            default:        data_d.val[0] = !slt;
          endcase
        end
      end
      nia_pkg::OP_ABS, nia_pkg::OP_NEG: begin
        if (ln) begin
          data_d.nul = 1'b1;
          data_d.knd = lk;
        end else if (lk) begin
          data_d.err = 1'b1;
        end else if (req_i.req_type == nia_pkg::OP_NEG || l[nia_pkg::DataW-1]) begin
          data_d.val = ~l + 1'b1;
        end else begin
          data_d.val = l;
        end
      end
      nia_pkg::OP_NOT: begin
        if (ln) begin
          data_d.nul = 1'b1;
          data_d.knd = nia_pkg::KIND_BOOL;
        end else if (!lk) begin
          data_d.err = 1'b1;
        end else begin
          data_d.knd    = nia_pkg::KIND_BOOL;
          data_d.val[0] = !lb;
        end
      end
      nia_pkg::OP_ISNULL: begin
        data_d.knd    = nia_pkg::KIND_BOOL;
        data_d.val[0] = ln;
      end
      nia_pkg::OP_NOTNULL: begin
        data_d.knd    = nia_pkg::KIND_BOOL;
        data_d.val[0] = !ln;
      end
      default: data_d.err = 1'b1;
    endcase
  end

  // stage register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign vld_o  = vld_q;
  assign data_o = data_q;

endmodule

// ===== sv/nia_cell.sv =====
// ---------------------------------------------------------------------------
// nia_cell: one step of the multiply / divide chain
// Does one shift-and-add multiply step or one restoring divide step and
// hands the request on to the next cell.
// ---------------------------------------------------------------------------
module nia_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           vld_i,
  input  nia_pkg::cell_t data_i,
  output logic           vld_o,
  output nia_pkg::cell_t data_o
);

  logic           vld_q;
  nia_pkg::cell_t data_d, data_q;
  logic [nia_pkg::DataW:0] rem_sh, rem_sub;

  // partial remainder with the next dividend bit shifted in
  assign rem_sh  = {data_i.acc, data_i.opa[nia_pkg::DataW-1]};
  assign rem_sub = rem_sh - {1'b0, data_i.opb};

  always_comb begin
    data_d = data_i;
    if (data_i.sel == nia_pkg::SEL_MUL) begin
      // add multiplicand for the current multiplier bit, wrap at 64 bits
      data_d.acc = data_i.acc + (data_i.opb[0] ? data_i.opa : '0);
      data_d.opa = {data_i.opa[nia_pkg::DataW-2:0], 1'b0};
      data_d.opb = {1'b0, data_i.opb[nia_pkg::DataW-1:1]};
    end else if (!rem_sub[nia_pkg::DataW]) begin
      data_d.acc = rem_sub[nia_pkg::DataW-1:0];
      data_d.opa = {data_i.opa[nia_pkg::DataW-2:0], 1'b1};
    end else begin
      data_d.acc = rem_sh[nia_pkg::DataW-1:0];
      data_d.opa = {data_i.opa[nia_pkg::DataW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign vld_o  = vld_q;
  assign data_o = data_q;

endmodule

// ===== sv/nia_back.sv =====
// ---------------------------------------------------------------------------
// nia_back: result select and sign fix-up
// Picks product, quotient, remainder or the direct value and registers the
// result with its strobe.
// ---------------------------------------------------------------------------
module nia_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           vld_i,
  input  nia_pkg::cell_t data_i,
  output logic           done_o,
  output nia_pkg::rsp_t  rsp_o
);

  logic          done_q;
  nia_pkg::rsp_t rsp_d, rsp_q;

  always_comb begin
    rsp_d.result_null = data_i.nul;
    rsp_d.result_kind = data_i.knd;
    rsp_d.type_error  = data_i.err;
    case (data_i.sel)
      nia_pkg::SEL_MUL: rsp_d.result_value = data_i.acc;
      nia_pkg::SEL_DIV: rsp_d.result_value = data_i.qneg ? (~data_i.opa + 1'b1) : data_i.opa;
      nia_pkg::SEL_MOD: rsp_d.result_value = data_i.rneg ? (~data_i.acc + 1'b1) : data_i.acc;
      default:          rsp_d.result_value = data_i.val;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

// ===== sv/null_aware_int_alu_unit.sv =====
// ---------------------------------------------------------------------------
// null_aware_int_alu_unit: null-aware 64-bit integer / boolean ALU
// Element-wise evaluator with null propagation and type checks; multiply,
// divide and remainder run down a chain of 64 one-step cells.
// ---------------------------------------------------------------------------
//  channel   | ports                    | direction
//  request   | start_i, busy_o, req_i   | in, taken when start_i & !busy_o
//  result    | done_o, rsp_o            | out, valid for the one cycle of done_o
//
//  One request per cycle; busy_o is always low.
//  Every result passes one decode stage, 64 chain cells (one multiply or
//  divide bit each) and one output register.
//  Results leave in request order; the receiver cannot stall.
//  Reset clears the valid bits of all stages; no result follows reset.
// ---------------------------------------------------------------------------
module null_aware_int_alu_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  input  nia_pkg::req_t req_i,
  output logic          done_o,
  output nia_pkg::rsp_t rsp_o
);

  logic           vld   [nia_pkg::NCells+1];
  nia_pkg::cell_t chain [nia_pkg::NCells+1];
  logic           accept;

  assign busy_o = 1'b0;
  assign accept = start_i & ~busy_o;

  // decode stage
  nia_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (accept),
    .req_i  (req_i),
    .vld_o  (vld[0]),
    .data_o (chain[0])
  );

  // multiply / divide cell chain
  for (genvar i = 0; i < nia_pkg::NCells; i++) begin : g_cell
    nia_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .vld_i  (vld[i]),
      .data_i (chain[i]),
      .vld_o  (vld[i+1]),
      .data_o (chain[i+1])
    );
  end

  // result stage
  nia_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (vld[nia_pkg::NCells]),
    .data_i (chain[nia_pkg::NCells]),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  // every request gives exactly one result after the fixed latency
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##(nia_pkg::Latency) done_o) else $error("result missing");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, nia_pkg::Latency)) else $error("unrequested result");

  a_err_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.type_error) |->
      (rsp_o.result_value == '0 && !rsp_o.result_null && !rsp_o.result_kind))
    else $error("type error with non-zero fields");

  a_null_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.result_null) |-> (rsp_o.result_value == '0))
    else $error("null result with value");

  a_bool_bit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.result_kind == nia_pkg::KIND_BOOL) |->
      (rsp_o.result_value[nia_pkg::DataW-1:1] == '0))
    else $error("boolean result wider than one bit");

endmodule
